// ===== design/iba_pkg.sv =====
package iba_pkg;

	// bitmap row geometry: blocks are kept eight to a memory word
	localparam int ROW_W    = 8;
	localparam int ROW_BITS = 3;

	localparam logic MODE_CREATE = 1'b0;
	localparam logic MODE_DELETE = 1'b1;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_DUP        = 3'd1;
	localparam logic [2:0] ST_NO_INODE   = 3'd2;
	localparam logic [2:0] ST_FEW_BLOCKS = 3'd3;
	localparam logic [2:0] ST_TOO_LARGE  = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd5;

	typedef struct packed {
		logic        mode;
		logic [63:0] file_name;
		logic [3:0]  size_blocks;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] inode_index;
		logic [3:0] blocks_changed;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;
		logic       scan_rd;
		logic       cnt_rd;
		logic       row_rst;
		logic       a_rd;
		logic       a_ld;
		logic       a_pick;
		logic       a_wb;
		logic       f_prd;
		logic       f_brd;
		logic       f_wr;
		logic       clr_wr;
		logic       set_st;
		logic [2:0] st;
		logic       out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
		logic row_last;
		logic found;
		logic free_found;
		logic too_large;
		logic size_zero;
		logic mode_del;
		logic enough;
		logic got_done;
		logic row_full;
		logic out_free;
	} sts_t;

endpackage

// ===== design/inode_block_allocator_top.sv =====
// Delete: a one-inode-per-cycle name scan, then a pointer read, bitmap read and
// bitmap write for each block of the file.
// Create: the same scan and a count of free blocks over the bitmap rows, then a
// read, load and write-back for each row touched plus one pick per block.
// Throughput: one item in flight; the next is taken once its result is registered.
// Reset: clears inode flags at once, then sweeps the bitmap one row per cycle.
module inode_block_allocator_top #(
	parameter int NUM_INODES      = 16,
	parameter int NUM_BLOCKS      = 128,
	parameter int MAX_FILE_BLOCKS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  iba_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output iba_pkg::rsp_t rsp
);
	import iba_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic idle;

	// Take an item only in idle; the result register lets the next item in while
	// the previous result still waits downstream.
	assign req_stall = !idle;

	// Sequence the scan, count, allocate and release passes.
	iba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.cmd       (cmd),
		.idle      (idle)
	);

	// Hold the inode table, block pointers, free bitmap and the result register.
	iba_datapath #(
		.NUM_INODES      (NUM_INODES),
		.NUM_BLOCKS      (NUM_BLOCKS),
		.MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.rsp       (rsp),
		.rsp_valid (rsp_valid)
	);

endmodule

// ===== design/iba_datapath.sv =====
module iba_datapath #(
	parameter int NUM_INODES      = 16,
	parameter int NUM_BLOCKS      = 128,
	parameter int MAX_FILE_BLOCKS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  iba_pkg::req_t req,
	input  iba_pkg::cmd_t cmd,
	input  logic          rsp_stall,
	output iba_pkg::sts_t sts,
	output iba_pkg::rsp_t rsp,
	output logic          rsp_valid
);
	import iba_pkg::*;

	localparam int IW    = $clog2(NUM_INODES);
	localparam int ROWS  = (NUM_BLOCKS + ROW_W - 1) / ROW_W;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PTR_W = $clog2(NUM_BLOCKS);
	localparam int CW    = $clog2(MAX_FILE_BLOCKS + 1);
	localparam int PD    = NUM_INODES * MAX_FILE_BLOCKS;
	localparam int PAW   = $clog2(PD);
	localparam int SUM_W = CW + ROW_BITS + 1;
	localparam logic [4:0] MFB_V = 5'(MAX_FILE_BLOCKS);

	// storage
	logic [63:0]       name_mem [NUM_INODES];
	logic [CW-1:0]     size_mem [NUM_INODES];
	logic [PTR_W-1:0]  ptr_mem  [PD];
	logic [ROW_W-1:0]  bm_mem   [ROWS];
	logic [NUM_INODES-1:0] inode_used_q;

	// request and walk state
	req_t           req_q;
	logic [IW-1:0]  scan_q;
	logic [RW-1:0]  row_q;
	logic [CW-1:0]  got_q;
	logic [CW-1:0]  size_q;
	logic [CW-1:0]  cnt_q;
	logic           found_q;
	logic           free_found_q;
	logic [IW-1:0]  match_idx_q;
	logic [IW-1:0]  free_idx_q;
	logic [2:0]     st_q;
	logic [ROW_W-1:0] rowbuf_q;
	logic [RW-1:0]  row_w_q;
	logic [ROW_BITS-1:0] bit_q;

	// memory read data
	logic           scan_v_s1;
	logic [IW-1:0]  scan_idx_s1;
	logic [63:0]    name_rd_s1;
	logic [CW-1:0]  size_rd_s1;
	logic           cnt_v_s1;
	logic [ROW_W-1:0] bm_rd_s1;
	logic [PTR_W-1:0] ptr_rd_s1;

	logic           rsp_valid_q;
	rsp_t           rsp_q;

	// combinational
	logic           name_hit;
	logic [ROW_BITS:0] pop;
	logic [SUM_W-1:0]  cnt_sum;
	logic [ROW_BITS-1:0] pick;
	logic [RW+ROW_BITS-1:0] blk_full;
	logic [PAW-1:0] pa_alloc;
	logic [PAW-1:0] pa_free;
	logic [ROW_W-1:0] clr_mask;
	logic           bm_we;
	logic [RW-1:0]  bm_waddr;
	logic [ROW_W-1:0] bm_wdata;
	logic           bm_re;
	logic [RW-1:0]  bm_raddr;
	logic           ok;
	logic           commit;
	rsp_t           rsp_d;

	function automatic logic [ROW_BITS-1:0] low_zero(input logic [ROW_W-1:0] r);
		logic [ROW_BITS-1:0] idx;
		idx = '0;
		for (int j = ROW_W - 1; j >= 0; j--) begin
			if (!r[j])
				idx = ROW_BITS'(j);
		end
		return idx;
	endfunction

	always_comb begin
		name_hit = scan_v_s1 && inode_used_q[scan_idx_s1] && (name_rd_s1 == req_q.file_name);
		pop = '0;
		for (int j = 0; j < ROW_W; j++)
			pop = pop + {{ROW_BITS{1'b0}}, ~bm_rd_s1[j]};
		cnt_sum = SUM_W'(cnt_q) + SUM_W'(pop);
		pick = low_zero(rowbuf_q);
		blk_full = {row_q, pick};
		pa_alloc = PAW'(free_idx_q) * PAW'(MAX_FILE_BLOCKS) + PAW'(got_q);
		pa_free  = PAW'(match_idx_q) * PAW'(MAX_FILE_BLOCKS) + PAW'(got_q);
		// blocks past the end of the disk sit in the last row, marked used
		for (int j = 0; j < ROW_W; j++)
			clr_mask[j] = ((int'(row_q) * ROW_W + j) >= NUM_BLOCKS);
	end

	// bitmap ports
	always_comb begin
		bm_we    = cmd.clr_wr | cmd.a_wb | cmd.f_wr;
		bm_waddr = cmd.f_wr ? row_w_q : row_q;
		if (cmd.clr_wr)
			bm_wdata = clr_mask;
		else if (cmd.a_wb)
			bm_wdata = rowbuf_q;
		else
			bm_wdata = bm_rd_s1 & ~(ROW_W'(1) << bit_q);
		bm_re    = cmd.cnt_rd | cmd.a_rd | cmd.f_brd;
		bm_raddr = cmd.f_brd ? RW'(ptr_rd_s1 >> ROW_BITS) : row_q;
	end

	always_ff @(posedge clk) begin
		if (bm_we)
			bm_mem[bm_waddr] <= bm_wdata;
		if (bm_re)
			bm_rd_s1 <= bm_mem[bm_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.a_pick)
			ptr_mem[pa_alloc] <= PTR_W'(blk_full);
		if (cmd.f_prd)
			ptr_rd_s1 <= ptr_mem[pa_free];
	end

	assign ok     = (st_q == ST_OK);
	assign commit = cmd.out_load && ok;

	always_ff @(posedge clk) begin
		if (commit && req_q.mode == MODE_CREATE) begin
			name_mem[free_idx_q] <= req_q.file_name;
			size_mem[free_idx_q] <= size_q;
		end
		if (cmd.scan_rd) begin
			name_rd_s1 <= name_mem[scan_q];
			size_rd_s1 <= size_mem[scan_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load)
			req_q <= req;
		if (cmd.scan_rd)
			scan_idx_s1 <= scan_q;
		if (cmd.f_brd) begin
			row_w_q <= RW'(ptr_rd_s1 >> ROW_BITS);
			bit_q   <= ptr_rd_s1[ROW_BITS-1:0];
		end
		if (cmd.a_ld)
			rowbuf_q <= bm_rd_s1;
		else if (cmd.a_pick)
			rowbuf_q[pick] <= 1'b1;
		if (cmd.out_load)
			rsp_q <= rsp_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inode_used_q <= '0;
			scan_q       <= '0;
			row_q        <= '0;
			got_q        <= '0;
			size_q       <= '0;
			cnt_q        <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			match_idx_q  <= '0;
			free_idx_q   <= '0;
			st_q         <= ST_OK;
			scan_v_s1    <= 1'b0;
			cnt_v_s1     <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			scan_v_s1 <= cmd.scan_rd;
			cnt_v_s1  <= cmd.cnt_rd;

			if (cmd.load) begin
				scan_q       <= '0;
				row_q        <= '0;
				got_q        <= '0;
				cnt_q        <= '0;
				size_q       <= CW'(req.size_blocks);
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					scan_q <= scan_q + 1'b1;
					// scan runs upward, so the last free one seen is the highest
					if (!inode_used_q[scan_q]) begin
						free_found_q <= 1'b1;
						free_idx_q   <= scan_q;
					end
				end
				if (name_hit && !found_q) begin
					found_q     <= 1'b1;
					match_idx_q <= scan_idx_s1;
					if (req_q.mode == MODE_DELETE)
						size_q <= size_rd_s1;
				end
				if (cnt_v_s1) begin
					if (cnt_sum >= SUM_W'(size_q))
						cnt_q <= size_q;
					else
						cnt_q <= CW'(cnt_sum);
				end
				if (cmd.row_rst)
					row_q <= '0;
				else if (cmd.clr_wr || cmd.cnt_rd || cmd.a_wb)
					row_q <= row_q + 1'b1;
				if (cmd.a_pick || cmd.f_wr)
					got_q <= got_q + 1'b1;
			end

			if (cmd.set_st)
				st_q <= cmd.st;

			if (commit) begin
				if (req_q.mode == MODE_CREATE)
					inode_used_q[free_idx_q] <= 1'b1;
				else
					inode_used_q[match_idx_q] <= 1'b0;
			end

			if (cmd.out_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		rsp_d.status         = st_q;
		rsp_d.inode_index    = ok ? 4'((req_q.mode == MODE_DELETE) ? match_idx_q : free_idx_q)
		                          : 4'd0;
		rsp_d.blocks_changed = ok ? 4'(size_q) : 4'd0;
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		sts.scan_last  = (scan_q == IW'(NUM_INODES - 1));
		sts.row_last   = (row_q == RW'(ROWS - 1));
		sts.found      = found_q;
		sts.free_found = free_found_q;
		sts.too_large  = ({1'b0, req_q.size_blocks} > MFB_V);
		sts.size_zero  = (size_q == '0);
		sts.mode_del   = (req_q.mode == MODE_DELETE);
		sts.enough     = (cnt_q >= size_q);
		sts.got_done   = (got_q == size_q);
		sts.row_full   = &rowbuf_q;
		sts.out_free   = !rsp_valid_q || !rsp_stall;
	end

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp_valid_q || !rsp_stall))
		else $error("result loaded over an untaken result");

	a_pick_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.a_pick |-> !(&rowbuf_q))
		else $error("block picked from a full bitmap row");

	a_got_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.a_pick || cmd.f_wr) |-> (got_q < size_q))
		else $error("block walk ran past the file size");

	a_free_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.f_prd |-> (found_q && req_q.mode == MODE_DELETE))
		else $error("block release without a matching inode");

endmodule

// ===== design/iba_ctrl.sv =====
module iba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  iba_pkg::sts_t sts,
	output iba_pkg::cmd_t cmd,
	output logic          idle
);
	import iba_pkg::*;

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_SCAN     = 4'd2;
	localparam logic [3:0] S_SCAN_END = 4'd3;
	localparam logic [3:0] S_DECIDE   = 4'd4;
	localparam logic [3:0] S_COUNT    = 4'd5;
	localparam logic [3:0] S_CNT_END  = 4'd6;
	localparam logic [3:0] S_CNT_CHK  = 4'd7;
	localparam logic [3:0] S_A_RD     = 4'd8;
	localparam logic [3:0] S_A_LD     = 4'd9;
	localparam logic [3:0] S_A_PICK   = 4'd10;
	localparam logic [3:0] S_F_PRD    = 4'd11;
	localparam logic [3:0] S_F_BRD    = 4'd12;
	localparam logic [3:0] S_F_WR     = 4'd13;
	localparam logic [3:0] S_RESP     = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		idle    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.row_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				idle = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last)
					state_d = S_SCAN_END;
			end
			S_SCAN_END: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.set_st = 1'b1;
				if (sts.mode_del) begin
					if (sts.found) begin
						cmd.st  = ST_OK;
						state_d = S_F_PRD;
					end else begin
						cmd.st  = ST_NOT_FOUND;
						state_d = S_RESP;
					end
				end else if (sts.too_large) begin
					cmd.st  = ST_TOO_LARGE;
					state_d = S_RESP;
				end else if (sts.found) begin
					cmd.st  = ST_DUP;
					state_d = S_RESP;
				end else if (!sts.free_found) begin
					cmd.st  = ST_NO_INODE;
					state_d = S_RESP;
				end else if (sts.size_zero) begin
					cmd.st  = ST_OK;
					state_d = S_RESP;
				end else begin
					cmd.set_st = 1'b0;
					state_d    = S_COUNT;
				end
			end
			S_COUNT: begin
				cmd.cnt_rd = 1'b1;
				if (sts.row_last)
					state_d = S_CNT_END;
			end
			S_CNT_END: begin
				state_d = S_CNT_CHK;
			end
			S_CNT_CHK: begin
				cmd.set_st = 1'b1;
				if (sts.enough) begin
					cmd.st      = ST_OK;
					cmd.row_rst = 1'b1;
					state_d     = S_A_RD;
				end else begin
					cmd.st  = ST_FEW_BLOCKS;
					state_d = S_RESP;
				end
			end
			S_A_RD: begin
				cmd.a_rd = 1'b1;
				state_d  = S_A_LD;
			end
			S_A_LD: begin
				cmd.a_ld = 1'b1;
				state_d  = S_A_PICK;
			end
			S_A_PICK: begin
				if (sts.got_done || sts.row_full) begin
					cmd.a_wb = 1'b1;
					state_d  = sts.got_done ? S_RESP : S_A_RD;
				end else begin
					cmd.a_pick = 1'b1;
				end
			end
			S_F_PRD: begin
				if (sts.got_done) begin
					state_d = S_RESP;
				end else begin
					cmd.f_prd = 1'b1;
					state_d   = S_F_BRD;
				end
			end
			S_F_BRD: begin
				cmd.f_brd = 1'b1;
				state_d   = S_F_WR;
			end
			S_F_WR: begin
				cmd.f_wr = 1'b1;
				state_d  = S_F_PRD;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

endmodule
